// File: src/json_string_escaper_defines.svh
// Assertion macros for the JSON string escaper.
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

`ifndef SYNTHESIS

`define JSE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jse: implication check failed");

`define JSE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jse: next-cycle check failed");

`else

`define JSE_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define JSE_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: src/jse_pkg.sv
package jse_pkg;

   localparam logic [1:0] OP_DATA  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;

   localparam logic [7:0] RAW_BS   = 8'h08;
   localparam logic [7:0] RAW_TAB  = 8'h09;
   localparam logic [7:0] RAW_LF   = 8'h0A;
   localparam logic [7:0] RAW_FF   = 8'h0C;
   localparam logic [7:0] RAW_CR   = 8'h0D;
   localparam logic [7:0] CTRL_MAX = 8'h1F;
   localparam logic [7:0] LEAD_E2  = 8'hE2;
   localparam logic [7:0] MID_80   = 8'h80;
   localparam logic [7:0] TAIL_A8  = 8'hA8;
   localparam logic [7:0] TAIL_A9  = 8'hA9;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      HELD_NONE = 2'd0,
      HELD_E2   = 2'd1,
      HELD_E280 = 2'd2
   } held_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_QUOTE = 3'd1,
      KIND_PASS  = 3'd2,
      KIND_ESC2  = 3'd3,
      KIND_UESC  = 3'd4,
      KIND_USEP  = 3'd5
   } kind_type;

   // flush: held bytes emitted ahead of the main sequence
   typedef struct packed {
      logic [1:0] flush;
      kind_type   kind;
      logic [7:0] arg;
   } job_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] r;
      if (nib < 4'd10) begin
         r = CH_ZERO + {4'd0, nib};
      end else begin
         r = CH_LA + {4'd0, nib} - 8'd10;
      end
      return r;
   endfunction

   function automatic logic [3:0] job_len(input job_type job);
      logic [3:0] m;
      case (job.kind)
         KIND_QUOTE, KIND_PASS: m = 4'd1;
         KIND_ESC2:             m = 4'd2;
         KIND_UESC, KIND_USEP:  m = 4'd6;
         default:               m = 4'd0;
      endcase
      return m + {2'd0, job.flush};
   endfunction

   function automatic logic [7:0] job_byte(input job_type job, input logic [2:0] idx);
      logic [2:0] k;
      logic [7:0] r;
      k = idx - {1'b0, job.flush};
      r = CH_QUOTE;
      if (idx < {1'b0, job.flush}) begin
         r = (idx == 3'd0) ? LEAD_E2 : MID_80;
      end else begin
         case (job.kind)
            KIND_QUOTE: r = CH_QUOTE;
            KIND_PASS:  r = job.arg;
            KIND_ESC2:  r = (k == 3'd0) ? CH_BSL : job.arg;
            KIND_UESC: begin
               case (k) inside
                  3'd0:       r = CH_BSL;
                  3'd1:       r = CH_U;
                  3'd2, 3'd3: r = CH_ZERO;
                  3'd4:       r = hex_char(job.arg[7:4]);
                  default:    r = hex_char(job.arg[3:0]);
               endcase
            end
            KIND_USEP: begin
               case (k) inside
                  3'd0:       r = CH_BSL;
                  3'd1:       r = CH_U;
                  3'd2, 3'd4: r = CH_TWO;
                  3'd3:       r = CH_ZERO;
                  default:    r = job.arg;
               endcase
            end
            default: r = CH_QUOTE;
         endcase
      end
      return r;
   endfunction

endpackage

// File: src/jse_front.sv
`include "json_string_escaper_defines.svh"

module jse_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [1:0]      opcode,
   input  logic [7:0]      data_byte,
   output logic            wr_en,
   output jse_pkg::job_type wr_job
);
   import jse_pkg::*;

   held_type held_ff;
   held_type held_in;
   job_type  job;
   logic     done;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= HELD_NONE;
      end else if (accept) begin
         held_ff <= held_in;
      end
   end

   always_comb begin
      held_in    = held_ff;
      job.flush  = 2'd0;
      job.kind   = KIND_NONE;
      job.arg    = data_byte;
      done       = 1'b0;
      unique case (opcode)
         OP_START, OP_END: begin
            job.flush = (held_ff == HELD_E2) ? 2'd1 : (held_ff == HELD_E280) ? 2'd2 : 2'd0;
            job.kind  = KIND_QUOTE;
            held_in   = HELD_NONE;
         end
         OP_DATA: begin
            held_in = HELD_NONE;
            unique case (held_ff)
               HELD_E2: begin
                  if (data_byte == MID_80) begin
                     held_in = HELD_E280;
                     done    = 1'b1;
                  end else begin
                     job.flush = 2'd1;
                  end
               end
               HELD_E280: begin
                  if (data_byte == TAIL_A8 || data_byte == TAIL_A9) begin
                     job.kind = KIND_USEP;
                     job.arg  = (data_byte == TAIL_A8) ? CH_EIGHT : CH_NINE;
                     done     = 1'b1;
                  end else begin
                     job.flush = 2'd2;
                  end
               end
               default: ;
            endcase
            if (!done) begin
               if (data_byte == LEAD_E2) begin
                  held_in = HELD_E2;
               end else begin
                  unique case (data_byte) inside
                     CH_BSL, CH_QUOTE: job.kind = KIND_ESC2;
                     RAW_BS:  begin job.kind = KIND_ESC2; job.arg = CH_B; end
                     RAW_FF:  begin job.kind = KIND_ESC2; job.arg = CH_F; end
                     RAW_LF:  begin job.kind = KIND_ESC2; job.arg = CH_N; end
                     RAW_CR:  begin job.kind = KIND_ESC2; job.arg = CH_R; end
                     RAW_TAB: begin job.kind = KIND_ESC2; job.arg = CH_T; end
                     default: job.kind = (data_byte <= CTRL_MAX) ? KIND_UESC : KIND_PASS;
                  endcase
               end
            end
         end
         default: ;  // unused opcode: no output, state kept
      endcase
   end

   assign wr_job = job;
   assign wr_en  = accept && (job_len(job) != 4'd0);

   `JSE_ASSERT_NXT(a_e2_starts_hold, clock, reset,
      accept && opcode == OP_DATA && data_byte == LEAD_E2 && held_ff == HELD_NONE,
      held_ff == HELD_E2)
   `JSE_ASSERT_NXT(a_e280_only_after_e2, clock, reset,
      held_ff == HELD_NONE, held_ff != HELD_E280)
   `JSE_ASSERT_IMP(a_hold_extend_silent, clock, reset,
      accept && opcode == OP_DATA && held_ff == HELD_E2 && data_byte == MID_80, !wr_en)

endmodule

// File: src/jse_queue.sv
`include "json_string_escaper_defines.svh"

module jse_queue #(
   parameter int QueueDepth = jse_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  jse_pkg::job_type wr_job,
   input  logic             rd_en,
   output jse_pkg::job_type rd_job,
   output logic             rd_valid,
   output logic             full
);
   import jse_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   job_type           slot_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff;
   logic [PtrW-1:0]   rd_ptr_ff;
   logic [CntW-1:0]   count_ff;
   logic [PtrW-1:0]   wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_in;

   assign full     = (count_ff == CntW'(QueueDepth));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_in;
         if (rd_en) rd_ptr_ff <= rd_ptr_in;
         case ({wr_en, rd_en})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `JSE_ASSERT_IMP(a_no_write_full, clock, reset, full, !wr_en)
   `JSE_ASSERT_IMP(a_no_read_empty, clock, reset, !rd_valid, !rd_en)
   `JSE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CntW'(QueueDepth))

endmodule

// File: src/jse_back.sv
`include "json_string_escaper_defines.svh"

module jse_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  jse_pkg::job_type q_job,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       out_byte,
   output logic             last
);
   import jse_pkg::*;

   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       load;
   logic       at_end;
   logic [3:0] len;

   assign len    = job_len(q_job);
   assign load   = q_valid && (!rsp_valid_ff || pop);
   assign at_end = ({1'b0, idx_ff} == len - 4'd1);
   assign q_pop  = load && at_end;
   assign idx_in = at_end ? 3'd0 : idx_ff + 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff <= idx_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= job_byte(q_job, idx_ff);
         rsp_last_ff <= at_end;
      end
   end

   assign empty    = !rsp_valid_ff;
   assign out_byte = rsp_byte_ff;
   assign last     = rsp_last_ff;

   `JSE_ASSERT_IMP(a_idx_in_range, clock, reset, q_valid, {1'b0, idx_ff} < len)
   `JSE_ASSERT_IMP(a_job_nonempty, clock, reset, q_valid, len != 4'd0 && len <= 4'd8)
   `JSE_ASSERT_NXT(a_pop_marks_last, clock, reset, q_pop, rsp_valid_ff && rsp_last_ff)

endmodule

// File: src/json_string_escaper.sv
// JSON string escaper.
// Input queue port: req_opcode (data byte, string start, string end) and
// req_data_byte, taken on a clock edge with push high and full low.
// Result queue port: rsp_out_byte and rsp_last are valid while empty is low
// and leave on a clock edge with pop high. rsp_last marks the final byte
// produced by one input item; items that only extend a held E2 / E2 80
// prefix produce nothing.
// The first byte of an item passes through the job queue and then the output
// register before it shows on the result port.
// Throughput: one result byte per cycle while pop is high, set by the single
// output register fed from the job queue; input runs at one item per cycle
// while escapes are short; the back end takes an n-byte item a byte at a time.
// The front end classifies and queues jobs (QueueDepth entries); full rises
// when that queue fills, so a stalled result side backs up into push.
// Reset (synchronous, active high) empties the queue, drops any held prefix
// bytes and marks the output register empty.
module json_string_escaper #(
   parameter int QueueDepth = jse_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_data_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import jse_pkg::*;

   logic    accept;
   logic    wr_en;
   job_type wr_job;
   logic    rd_en;
   job_type rd_job;
   logic    rd_valid;
   logic    q_full;

   assign accept = push && !q_full;
   assign full   = q_full;

   jse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (req_opcode),
      .data_byte (req_data_byte),
      .wr_en     (wr_en),
      .wr_job    (wr_job)
   );

   jse_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_job   (wr_job),
      .rd_en    (rd_en),
      .rd_job   (rd_job),
      .rd_valid (rd_valid),
      .full     (q_full)
   );

   jse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (rd_valid),
      .q_job    (rd_job),
      .q_pop    (rd_en),
      .pop      (pop),
      .empty    (empty),
      .out_byte (rsp_out_byte),
      .last     (rsp_last)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import jse_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam logic [127:0] HEX_TEXT  = "0123456789abcdef";

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [1:0] req_opcode = OP_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   // escaped text expected on the result port, oldest first
   text_char_type pending_text[$];
   text_char_type want;
   held_type      prefix_state = HELD_NONE;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_len = 0;
   logic holding = 1'b0;
   event hold_go;
   int error_count = 0;
   int cycle_count = 0;

   json_string_escaper uut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_opcode    (req_opcode),
      .req_data_byte (req_data_byte),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- escaped-text predictor ----------------

   function automatic void emit(input logic [7:0] ch);
      text_char_type entry;
      entry.ch = ch;
      entry.last = 1'b0;
      pending_text.insert(pending_text.size(), entry);
   endfunction

   function automatic void flush_prefix();
      if (prefix_state == HELD_E2 || prefix_state == HELD_E280) emit(LEAD_E2);
      if (prefix_state == HELD_E280) emit(MID_80);
      prefix_state = HELD_NONE;
   endfunction

   function automatic void emit_escaped(input logic [7:0] b);
      case (b)
         CH_BSL:   begin emit(CH_BSL); emit(CH_BSL); end
         CH_QUOTE: begin emit(CH_BSL); emit(CH_QUOTE); end
         RAW_BS:   begin emit(CH_BSL); emit(CH_B); end
         RAW_FF:   begin emit(CH_BSL); emit(CH_F); end
         RAW_LF:   begin emit(CH_BSL); emit(CH_N); end
         RAW_CR:   begin emit(CH_BSL); emit(CH_R); end
         RAW_TAB:  begin emit(CH_BSL); emit(CH_T); end
         default: begin
            if (b <= CTRL_MAX) begin
               emit(CH_BSL);
               emit(CH_U);
               emit(CH_ZERO);
               emit(CH_ZERO);
               emit(HEX_TEXT[8 * (15 - b[7:4]) +: 8]);
               emit(HEX_TEXT[8 * (15 - b[3:0]) +: 8]);
            end else begin
               emit(b);
            end
         end
      endcase
   endfunction

   function automatic void predict_item(input logic [1:0] op, input logic [7:0] b);
      int   base;
      logic done;
      base = pending_text.size();
      done = 1'b0;
      if (op == OP_START || op == OP_END) begin
         flush_prefix();
         emit(CH_QUOTE);
      end else if (op == OP_DATA) begin
         case (prefix_state)
            HELD_E2: begin
               if (b == MID_80) begin
                  prefix_state = HELD_E280;
                  done = 1'b1;
               end else begin
                  flush_prefix();
               end
            end
            HELD_E280: begin
               if (b == TAIL_A8 || b == TAIL_A9) begin
                  emit(CH_BSL);
                  emit(CH_U);
                  emit(CH_TWO);
                  emit(CH_ZERO);
                  emit(CH_TWO);
                  emit((b == TAIL_A8) ? CH_EIGHT : CH_NINE);
                  prefix_state = HELD_NONE;
                  done = 1'b1;
               end else begin
                  flush_prefix();
               end
            end
            default: prefix_state = HELD_NONE;
         endcase
         if (!done) begin
            if (b == LEAD_E2) prefix_state = HELD_E2;
            else emit_escaped(b);
         end
      end
      if (pending_text.size() > base) pending_text[pending_text.size() - 1].last = 1'b1;
   endfunction

   // ---------------- driving and checking ----------------

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      error_count++;
   endtask

   // call at a falling edge; returns at the falling edge after the item is taken
   task automatic send_item(input logic [1:0] op, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_item(op, b);
      @(negedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (pending_text.size() != 0) @(negedge clock);
      // an item that only extends a hold may still be in flight
      repeat (8) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || holding) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_go);
         holding <= 1'b1;
         repeat (hold_len) @(posedge clock);
         holding <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_text.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h", rsp_out_byte));
         end else begin
            want = pending_text.pop_front();
            if (rsp_out_byte !== want.ch)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, want.ch));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                         rsp_last, want.last, want.ch));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   function automatic logic [7:0] pick_text_byte();
      int r;
      logic [7:0] b;
      r = $urandom_range(99);
      if (r < 45) b = 8'($urandom_range(8'h7E, 8'h20));
      else if (r < 60) b = 8'($urandom_range(31, 0));
      else if (r < 75) begin
         case ($urandom_range(6))
            0: b = RAW_BS;
            1: b = RAW_TAB;
            2: b = RAW_LF;
            3: b = RAW_FF;
            4: b = RAW_CR;
            5: b = CH_QUOTE;
            default: b = CH_BSL;
         endcase
      end else if (r < 85) b = 8'($urandom_range(255, 128));
      else b = 8'($urandom);
      return b;
   endfunction

   // framed strings, mostly well formed; some separators cut short,
   // some frames missing a start or end, some unused opcodes
   task automatic send_random_text(input int budget);
      int sent;
      int len;
      int k;
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 5) send_item(OP_UNUSED, 8'($urandom));
         if ($urandom_range(99) >= 6) begin
            send_item(OP_START, 8'($urandom));
            sent++;
         end
         len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 18) begin
               k = ($urandom_range(99) < 70) ? 3 : $urandom_range(2, 1);
               send_item(OP_DATA, LEAD_E2);
               if (k > 1) send_item(OP_DATA, MID_80);
               if (k > 2) begin
                  if ($urandom_range(3) == 0) send_item(OP_DATA, 8'($urandom));
                  else send_item(OP_DATA, $urandom_range(1) ? TAIL_A8 : TAIL_A9);
               end
               sent += k;
            end else begin
               send_item(OP_DATA, pick_text_byte());
               sent++;
            end
         end
         if ($urandom_range(99) >= 6) begin
            send_item(OP_END, 8'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_item(OP_START, 8'hFF);
      send_item(OP_DATA, 8'h00);
      send_item(OP_DATA, RAW_BS);
      send_item(OP_DATA, RAW_TAB);
      send_item(OP_DATA, RAW_LF);
      send_item(OP_DATA, RAW_FF);
      send_item(OP_DATA, RAW_CR);
      send_item(OP_DATA, CTRL_MAX);
      send_item(OP_DATA, CH_QUOTE);
      send_item(OP_DATA, CH_BSL);
      send_item(OP_DATA, 8'h7F);
      send_item(OP_DATA, 8'hFF);
      // line and paragraph separators
      send_item(OP_DATA, LEAD_E2);
      send_item(OP_DATA, MID_80);
      send_item(OP_DATA, TAIL_A8);
      send_item(OP_DATA, LEAD_E2);
      send_item(OP_DATA, MID_80);
      send_item(OP_DATA, TAIL_A9);
      // broken after E2, then after E2 80 with a new lead byte
      send_item(OP_DATA, LEAD_E2);
      send_item(OP_DATA, 8'h41);
      send_item(OP_DATA, LEAD_E2);
      send_item(OP_DATA, MID_80);
      send_item(OP_DATA, LEAD_E2);
      send_item(OP_UNUSED, 8'hAA);   // ignored, hold kept
      send_item(OP_END, 8'h00);      // flushes E2 before the quote
      send_item(OP_DATA, LEAD_E2);
      send_item(OP_DATA, MID_80);
      send_item(OP_START, 8'h00);    // flushes E2 80 before the quote
      drain();
   endtask

   task automatic test_streaming();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random_text(70);
      drain();
   endtask

   task automatic test_sender_gaps();
      send_idle_pct = 74;
      recv_stall_pct = 0;
      send_random_text(70);
      drain();
   endtask

   task automatic test_receiver_stalls();
      send_idle_pct = 0;
      recv_stall_pct = 74;
      send_random_text(70);
      drain();
   endtask

   task automatic test_both_idle();
      send_idle_pct = 11;
      recv_stall_pct = 11;
      send_random_text(70);
      drain();
   endtask

   // receiver holds off while control bytes pile up and full rises
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_len = 150;
      -> hold_go;
      send_item(OP_START, 8'h00);
      for (int i = 0; i < 20; i++) send_item(OP_DATA, 8'($urandom_range(31, 0)));
      send_item(OP_END, 8'h00);
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_backpressure();
      recv_stall_pct = 0;
      repeat (20) @(posedge clock);
      if (pending_text.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", pending_text.size()));
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/jse_pkg.sv
src/jse_front.sv
src/jse_queue.sv
src/jse_back.sv
src/json_string_escaper.sv
tb/tb_top.sv
